// ===== sv/oda_pkg.sv =====
package oda_pkg;

  // default saturation point of the hit and miss run counters
  localparam int unsigned RunCountMaxDef = 255;

  // alarm level, one-hot
  typedef enum logic [2:0] {
    LVL_IDLE = 3'b001,
    LVL_WARN = 3'b010,
    LVL_OCC  = 3'b100
  } level_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_HITS   = 2'd0,
    REG_MISSES = 2'd1,
    REG_WARN   = 2'd2,
    REG_ALARM  = 2'd3
  } cfg_idx_e;

  // configuration register set
  typedef struct packed {
    logic [7:0]  hits_to_present;
    logic [7:0]  misses_to_clear;
    logic [19:0] warn_delay_ms;
    logic [19:0] alarm_delay_ms;
  } cfg_t;

  // one frame event
  typedef struct packed {
    logic        target_seen;
    logic        flame_near;
    logic        flame_remote;
    logic [31:0] now_ms;
  } in_item_t;

  // one result
  typedef struct packed {
    logic [1:0]  alarm_code;
    logic        send_cmd;
    logic        snapshot;
    logic [31:0] dwell_ms;
    logic [9:0]  countdown_s;
  } out_item_t;

  // tracker result handed to the countdown stage
  typedef struct packed {
    logic [1:0]  alarm_code;
    logic        send_cmd;
    logic        snapshot;
    logic [31:0] dwell_ms;
    logic        cd_en;
    logic [19:0] cd_rem;
  } step_res_t;

endpackage

// ===== sv/obstruction_dwell_alarm_fsm.sv =====
// Obstruction dwell alarm controller.
// Input channel in_valid_i / in_ready_o carries one frame event per beat:
// target bit, local and remote flame bits and a wrapping millisecond stamp.
// Output channel out_valid_o / out_ready_i returns exactly one result per
// event, in order: alarm code, send flag, snapshot pulse, dwell, countdown.
// From input beat to result valid an event passes three registers: input
// register, state update stage, countdown stage (divide by 1000 as a
// reciprocal multiply) into the output register. Throughput is one event
// per cycle while the receiver accepts; each stage holds one beat and moves
// as soon as the next one is free, so a stalled receiver backs up at most
// three beats before in_ready_o drops.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes one
// register per cycle, with no wait; write only while no beat is in flight.
// Reset clears fire mode, presence, counters and the sent-state memory, and
// loads the register defaults (3 hits, 3 misses, 3000 ms warn, 5000 ms alarm).
module obstruction_dwell_alarm_fsm import oda_pkg::*; #(
  parameter int unsigned RunCountMax = RunCountMaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o
);

  localparam logic [17:0] CdRecip = 18'd134218;
  localparam int unsigned CdShift = 24;
  localparam logic [10:0] CdMax   = 11'd1023;

  cfg_t      cfg_q;
  in_item_t  in_q;
  logic      a_valid_q, b_valid_q, o_valid_q;
  step_res_t res, b_res_q;
  out_item_t out_q, out_d;
  logic      a_adv, b_adv, b_free, o_free;
  logic [34:0] cd_prod;
  logic [10:0] cd_quot;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hits_to_present <= 8'd3;
      cfg_q.misses_to_clear <= 8'd3;
      cfg_q.warn_delay_ms   <= 20'd3000;
      cfg_q.alarm_delay_ms  <= 20'd5000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_HITS:   cfg_q.hits_to_present <= cfg_wdata_i[7:0];
        REG_MISSES: cfg_q.misses_to_clear <= cfg_wdata_i[7:0];
        REG_WARN:   cfg_q.warn_delay_ms   <= cfg_wdata_i;
        REG_ALARM:  cfg_q.alarm_delay_ms  <= cfg_wdata_i;
        default:    cfg_q.hits_to_present <= cfg_q.hits_to_present;
      endcase
    end
  end

  // pipeline flow control
  assign o_free     = !o_valid_q || out_ready_i;
  assign b_adv      = b_valid_q && o_free;
  assign b_free     = !b_valid_q || b_adv;
  assign a_adv      = a_valid_q && b_free;
  assign in_ready_o = !a_valid_q || a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      a_valid_q <= (in_valid_i && in_ready_o) || (a_valid_q && !a_adv);
      b_valid_q <= a_adv || (b_valid_q && !b_adv);
      o_valid_q <= b_adv || (o_valid_q && !out_ready_i);
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  // state update stage
  oda_track #(
    .RunCountMax(RunCountMax)
  ) u_track (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(a_adv),
    .item_i(in_q),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_res_q <= res;
    end
  end

  // countdown: remaining ms / 1000 as (rem >> 3) / 125 by reciprocal multiply
  assign cd_prod = 35'(b_res_q.cd_rem[19:3]) * 35'(CdRecip);
  assign cd_quot = cd_prod[CdShift +: 11];

  always_comb begin
    out_d.alarm_code = b_res_q.alarm_code;
    out_d.send_cmd   = b_res_q.send_cmd;
    out_d.snapshot   = b_res_q.snapshot;
    out_d.dwell_ms   = b_res_q.dwell_ms;
    if (!b_res_q.cd_en) begin
      out_d.countdown_s = '0;
    end else if (cd_quot > CdMax) begin
      out_d.countdown_s = CdMax[9:0];
    end else begin
      out_d.countdown_s = cd_quot[9:0];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== sv/oda_track.sv =====
module oda_track import oda_pkg::*; #(
  parameter int unsigned RunCountMax = RunCountMaxDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output step_res_t res_o
);

  localparam int unsigned RunW = $clog2(RunCountMax + 1);
  localparam int unsigned CmpW = (RunW > 8) ? RunW : 8;
  localparam logic [RunW-1:0] RunSat = RunW'(RunCountMax);

  // alarm code of a level
  function automatic logic [1:0] level_code(level_e lvl);
    logic [1:0] code;
    unique case (lvl)
      LVL_IDLE: code = 2'd0;
      LVL_WARN: code = 2'd1;
      LVL_OCC:  code = 2'd2;
      default:  code = 2'd0;
    endcase
    return code;
  endfunction

  logic            fire_q, fire_d;
  logic            obj_q, obj_d;
  level_e          level_q, level_d;
  logic [RunW-1:0] hit_q, hit_d;
  logic [RunW-1:0] miss_q, miss_d;
  logic [31:0]     start_q, start_d;
  logic            sent_valid_q, sent_valid_d;
  level_e          sent_level_q, sent_level_d;
  logic            sent_fire_q, sent_fire_d;

  logic            flame;
  logic [CmpW-1:0] need_hits, need_miss;
  logic [31:0]     warn_ext, alarm_ext;
  logic [31:0]     dwell;
  logic            send, snap, cd_en;
  logic [1:0]      code;

  assign flame     = item_i.flame_near | item_i.flame_remote;
  assign need_hits = (cfg_i.hits_to_present == 8'd0) ? CmpW'(1) : CmpW'(cfg_i.hits_to_present);
  assign need_miss = (cfg_i.misses_to_clear == 8'd0) ? CmpW'(1) : CmpW'(cfg_i.misses_to_clear);
  assign warn_ext  = {12'd0, cfg_i.warn_delay_ms};
  assign alarm_ext = {12'd0, cfg_i.alarm_delay_ms};

  // per-frame update of fire mode, presence debounce and alarm level
  always_comb begin
    fire_d       = fire_q;
    obj_d        = obj_q;
    level_d      = level_q;
    hit_d        = hit_q;
    miss_d       = miss_q;
    start_d      = start_q;
    sent_valid_d = sent_valid_q;
    sent_level_d = sent_level_q;
    sent_fire_d  = sent_fire_q;
    snap         = 1'b0;
    send         = 1'b0;
    dwell        = '0;
    cd_en        = 1'b0;
    code         = 2'd0;

    // fire onset latches, fire end clears the presence logic
    if (flame) begin
      if (!fire_q) begin
        fire_d = 1'b1;
        snap   = 1'b1;
      end
    end else if (fire_q) begin
      fire_d  = 1'b0;
      level_d = LVL_IDLE;
      obj_d   = 1'b0;
      hit_d   = '0;
      miss_d  = '0;
    end

    if (fire_d) begin
      send        = 1'b1;
      sent_fire_d = 1'b1;
      code        = 2'd3;
    end else begin
      // saturating run counters
      if (item_i.target_seen) begin
        hit_d  = (hit_d >= RunSat) ? RunSat : hit_d + 1'b1;
        miss_d = '0;
      end else begin
        miss_d = (miss_d >= RunSat) ? RunSat : miss_d + 1'b1;
        hit_d  = '0;
      end

      // presence debounce
      if (CmpW'(hit_d) >= need_hits && !obj_d) begin
        obj_d   = 1'b1;
        start_d = item_i.now_ms;
      end else if (CmpW'(miss_d) >= need_miss && obj_d) begin
        obj_d   = 1'b0;
        level_d = LVL_IDLE;
      end

      // dwell thresholds
      if (obj_d) begin
        dwell = item_i.now_ms - start_d;
        if (level_d == LVL_IDLE && dwell >= warn_ext) begin
          level_d = LVL_WARN;
        end else if (level_d == LVL_WARN && dwell >= alarm_ext) begin
          level_d = LVL_OCC;
          snap    = 1'b1;
        end
      end else begin
        level_d = LVL_IDLE;
      end

      cd_en = (level_d == LVL_WARN) && obj_d && (dwell < alarm_ext);

      // send on change
      if (!sent_valid_q || level_d != sent_level_q || sent_fire_q) begin
        send         = 1'b1;
        sent_valid_d = 1'b1;
        sent_level_d = level_d;
        sent_fire_d  = 1'b0;
      end
      code = level_code(level_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fire_q       <= 1'b0;
      obj_q        <= 1'b0;
      level_q      <= LVL_IDLE;
      hit_q        <= '0;
      miss_q       <= '0;
      start_q      <= '0;
      sent_valid_q <= 1'b0;
      sent_level_q <= LVL_IDLE;
      sent_fire_q  <= 1'b0;
    end else if (step_i) begin
      fire_q       <= fire_d;
      obj_q        <= obj_d;
      level_q      <= level_d;
      hit_q        <= hit_d;
      miss_q       <= miss_d;
      start_q      <= start_d;
      sent_valid_q <= sent_valid_d;
      sent_level_q <= sent_level_d;
      sent_fire_q  <= sent_fire_d;
    end
  end

  assign res_o.alarm_code = code;
  assign res_o.send_cmd   = send;
  assign res_o.snapshot   = snap;
  assign res_o.dwell_ms   = dwell;
  assign res_o.cd_en      = cd_en;
  assign res_o.cd_rem     = cfg_i.alarm_delay_ms - dwell[19:0];

endmodule
